// ===== hdl/skrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_pkg: shared types and constants for the session key rotation table
// Entry and per-cell flag layouts, field widths, command codes and the
// saturating time adder.
// ----------------------------------------------------------------------------
package skrt_pkg;

    localparam int TIME_W = 40;
    localparam int NAME_W = 64;
    localparam int LIFE_W = 32;
    localparam int CMD_W  = 2;
    localparam int OUT_COUNT_W = 4;

    localparam logic [TIME_W-1:0] AHEAD_SECONDS  = TIME_W'(60);
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(3600);

    localparam logic [CMD_W-1:0] CMD_ROTATE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECRYPT = 2'd2;

    // One stored key entry; validity window is [t_start, t_stop].
    typedef struct packed {
        logic [NAME_W-1:0] name_hi;
        logic [NAME_W-1:0] name_lo;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_stop;
    } entry_t;

    // Compare results a cell registers against the current request.
    typedef struct packed {
        logic started;    // t_start <= now
        logic in_window;  // now <= t_stop
        logic name_eq;    // stored name equals request name
    } flags_t;

    // Time sum clamped to the all-ones time value.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/session_key_rotation_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// session_key_rotation_table_unit: newest-first session key table
// Rotates, looks up and matches key entries held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//  - A request (cmd, now, name_hi, name_lo) is taken on a clock edge with
//    start high and busy low. cmd: rotate, encrypt lookup, decrypt lookup.
//  - busy stays high after the accepting edge through compare (every
//    cell registers its window and name compares in parallel), then decide
//    (priority pick across the cells, table shift and fill count update).
//  - The result shows on hit/renew/altered/out_name_*/entry_count for
//    exactly one cycle with done high, in the cycle busy drops. A new
//    request may be issued in that same cycle; no new request is taken
//    while one is in the compare register stage or the decide stage.
//  - The receiver cannot stall; done is a one-cycle strobe.
//  - lifetime is written through cfg_valid/cfg_data; cfg_ready is always
//    high. Write it only while no request is in flight.
//  - Reset empties the table (fill count zero) and sets lifetime to 3600.
//    No clearing pass is needed; slot contents are gated by the fill count.
//  - An insertion shifts every cell toward the old end by one slot; the
//    oldest slot falls off when the table is full.
// ----------------------------------------------------------------------------
module session_key_rotation_table_unit #(
    parameter int ENTRIES = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output      logic                             busy,
    input  wire logic [skrt_pkg::CMD_W-1:0]       cmd,
    input  wire logic [skrt_pkg::TIME_W-1:0]      now,
    input  wire logic [skrt_pkg::NAME_W-1:0]      name_hi,
    input  wire logic [skrt_pkg::NAME_W-1:0]      name_lo,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [skrt_pkg::LIFE_W-1:0]      cfg_data,
    output      logic                             done,
    output      logic                             hit,
    output      logic                             renew,
    output      logic                             altered,
    output      logic [skrt_pkg::NAME_W-1:0]      out_name_hi,
    output      logic [skrt_pkg::NAME_W-1:0]      out_name_lo,
    output      logic [skrt_pkg::OUT_COUNT_W-1:0] entry_count
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = CNT_W + skrt_pkg::OUT_COUNT_W;
    localparam int TW    = skrt_pkg::TIME_W;
    localparam int NW    = skrt_pkg::NAME_W;
    localparam int LW    = skrt_pkg::LIFE_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    // ---------------------------------------------------------------- control
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [LW-1:0]    lifetime_reg;

    // request capture
    logic [skrt_pkg::CMD_W-1:0] cmd_reg;
    logic [TW-1:0]              now_reg;
    logic [NW-1:0]              nhi_reg, nlo_reg;

    // compare stage results
    logic          thresh_reg;   // start of newest entry + lifetime/4 < now
    logic [TW-1:0] n60_reg;      // now + 60, saturated
    logic [TW-1:0] nl_reg;       // now + lifetime - 1, saturated

    // result registers
    logic          done_reg, hit_reg, renew_reg, altered_reg;
    logic          hit_next, renew_next, altered_next;
    logic [NW-1:0] ohi_reg, olo_reg, ohi_next, olo_next;

    logic accept;
    logic eval_en;
    logic decide;
    logic shift_en;

    assign accept    = start && !busy;
    assign busy      = state_reg != ST_IDLE;
    assign eval_en   = state_reg == ST_EVAL;
    assign decide    = state_reg == ST_DECIDE;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- chain
    skrt_pkg::entry_t chain [ENTRIES+1];
    skrt_pkg::flags_t flags [ENTRIES];
    skrt_pkg::entry_t new_entry;

    assign chain[0] = new_entry;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        skrt_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .eval_en  (eval_en),
            .prev     (chain[g]),
            .now      (now_reg),
            .name_hi  (nhi_reg),
            .name_lo  (nlo_reg),
            .cur      (chain[g+1]),
            .flags    (flags[g])
        );
    end

    // ---------------------------------------------------------------- compare stage
    // Effective lifetime: a zero register counts as one second.
    logic [LW-1:0] life_m1;
    logic [TW-1:0] quarter_sum;

    assign life_m1     = (lifetime_reg == '0) ? '0 : lifetime_reg - LW'(1);
    assign quarter_sum = skrt_pkg::sat_add(chain[1].t_start,
                                           {{(TW-LW){1'b0}}, lifetime_reg >> 2});

    always_ff @(posedge clk)
    begin
        if (eval_en)
        begin
            thresh_reg <= quarter_sum < now_reg;
            n60_reg    <= skrt_pkg::sat_add(now_reg, skrt_pkg::AHEAD_SECONDS);
            nl_reg     <= skrt_pkg::sat_add(now_reg, {{(TW-LW){1'b0}}, life_m1});
        end
    end

    // ---------------------------------------------------------------- decide stage
    logic [ENTRIES-1:0] live;
    logic [ENTRIES-1:0] use_oh;      // newest started entry
    logic [ENTRIES-1:0] match_vec;
    logic [CNT_W-1:0]   held_drop;   // fill count after expiry from old end
    logic [CNT_W-1:0]   held_cap;
    logic               usable;
    logic               match_any;
    logic               insert;
    logic [NW-1:0]      use_hi, use_lo;
    logic [TW-1:0]      nb, ne;

    always_comb
    begin
        logic seen;
        seen      = 1'b0;
        held_drop = '0;
        use_hi    = '0;
        use_lo    = '0;
        usable    = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            live[i]      = CNT_W'(i) < held_reg;
            match_vec[i] = live[i] && flags[i].name_eq;
            use_oh[i]    = live[i] && flags[i].started && !seen;
            seen         = seen || (live[i] && flags[i].started);
            if (live[i] && flags[i].in_window)
            begin
                held_drop = CNT_W'(i + 1);
            end
            usable = usable || (use_oh[i] && flags[i].in_window);
            use_hi = use_hi | (chain[i+1].name_hi & {NW{use_oh[i]}});
            use_lo = use_lo | (chain[i+1].name_lo & {NW{use_oh[i]}});
        end
    end

    // An entry dropped by expiry is never usable, so the usable test over the
    // pre-expiry table gives the same answer as over the trimmed one.
    assign match_any = |match_vec;
    assign insert    = decide && (cmd_reg == skrt_pkg::CMD_ROTATE) &&
                       (!usable || thresh_reg);
    assign shift_en  = insert;
    assign held_cap  = (held_drop >= CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES - 1) : held_drop;

    assign nb = usable ? n60_reg : now_reg;
    assign ne = usable ? skrt_pkg::sat_add(nl_reg, skrt_pkg::AHEAD_SECONDS) : nl_reg;

    assign new_entry.name_hi = nhi_reg;
    assign new_entry.name_lo = nlo_reg;
    assign new_entry.t_start = nb;
    assign new_entry.t_stop  = ne;

    always_comb
    begin
        held_next    = held_reg;
        hit_next     = 1'b0;
        renew_next   = 1'b0;
        altered_next = 1'b0;
        ohi_next     = '0;
        olo_next     = '0;
        case (cmd_reg)
            skrt_pkg::CMD_ROTATE:
            begin
                held_next    = insert ? held_cap + CNT_W'(1) : held_drop;
                altered_next = insert || (held_drop != held_reg);
            end
            skrt_pkg::CMD_ENCRYPT:
            begin
                hit_next = usable;
                ohi_next = usable ? use_hi : '0;
                olo_next = usable ? use_lo : '0;
            end
            skrt_pkg::CMD_DECRYPT:
            begin
                hit_next   = match_any;
                renew_next = match_any && !match_vec[0];
                ohi_next   = match_any ? nhi_reg : '0;
                olo_next   = match_any ? nlo_reg : '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_EVAL : ST_IDLE;
            ST_EVAL:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            held_reg     <= '0;
            lifetime_reg <= skrt_pkg::LIFETIME_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= decide;
            if (decide)
            begin
                held_reg <= held_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                lifetime_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            now_reg <= now;
            nhi_reg <= name_hi;
            nlo_reg <= name_lo;
        end
        if (decide)
        begin
            hit_reg     <= hit_next;
            renew_reg   <= renew_next;
            altered_reg <= altered_next;
            ohi_reg     <= ohi_next;
            olo_reg     <= olo_next;
        end
    end

    // ---------------------------------------------------------------- outputs
    // held_reg only changes at the end of a decide cycle, so it is steady
    // while the strobe is up.
    logic [EXT_W-1:0] count_ext;

    assign count_ext   = EXT_W'(held_reg);
    assign entry_count = count_ext[skrt_pkg::OUT_COUNT_W-1:0];
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign renew       = renew_reg;
    assign altered     = altered_reg;
    assign out_name_hi = ohi_reg;
    assign out_name_lo = olo_reg;

endmodule
`default_nettype wire

// ===== hdl/skrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_cell: one slot of the key table chain
// Holds one entry, takes its neighbor's entry on a shift and registers its
// own time window and name compares for the request in flight.
// ----------------------------------------------------------------------------
module skrt_cell (
    input  wire logic                        clk,
    input  wire logic                        shift_en,
    input  wire logic                        eval_en,
    input  wire skrt_pkg::entry_t            prev,
    input  wire logic [skrt_pkg::TIME_W-1:0] now,
    input  wire logic [skrt_pkg::NAME_W-1:0] name_hi,
    input  wire logic [skrt_pkg::NAME_W-1:0] name_lo,
    output skrt_pkg::entry_t                 cur,
    output skrt_pkg::flags_t                 flags
);

    skrt_pkg::entry_t entry_reg;
    skrt_pkg::flags_t flags_reg;
    skrt_pkg::flags_t flags_next;

    always_comb
    begin
        flags_next.started   = entry_reg.t_start <= now;
        flags_next.in_window = now <= entry_reg.t_stop;
        flags_next.name_eq   = (entry_reg.name_hi == name_hi) &&
                               (entry_reg.name_lo == name_lo);
    end

    // payload only, no reset: slots past the fill count are never looked at
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= prev;
        end
        if (eval_en)
        begin
            flags_reg <= flags_next;
        end
    end

    assign cur   = entry_reg;
    assign flags = flags_reg;

endmodule
`default_nettype wire

// ===== tb/session_key_rotation_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_key_rotation_table_unit_test: self-checking bench for the key table
// Walks a directed table of rotate/encrypt/decrypt requests, then several
// random phases at different lifetimes. Every done strobe is checked, field
// by field, against a typed row's reply or an in-bench model of the newest-first key table.
// ----------------------------------------------------------------------------
module session_key_rotation_table_unit_test;
    import skrt_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;
    // Code the block must treat as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result as it shows on the result ports.
    typedef struct packed {
        logic                   hit;
        logic                   renew;
        logic                   altered;
        logic [NAME_W-1:0]      name_hi;
        logic [NAME_W-1:0]      name_lo;
        logic [OUT_COUNT_W-1:0] count;
    } key_reply_t;

    typedef enum logic {ROW_REQUEST, ROW_LIFETIME} row_kind_e;

    // One line of the directed table: either a request or a lifetime write.
    // typed rows carry a hand-written reply; the rest use the table model.
    typedef struct {
        row_kind_e         kind;
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] t;
        logic [NAME_W-1:0] nhi;
        logic [NAME_W-1:0] nlo;
        logic [LIFE_W-1:0] life;
        bit                typed;
        key_reply_t        want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    logic [CMD_W-1:0]       cmd       = '0;
    logic [TIME_W-1:0]      now       = '0;
    logic [NAME_W-1:0]      name_hi   = '0;
    logic [NAME_W-1:0]      name_lo   = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LIFE_W-1:0]      cfg_data  = '0;
    logic                   done;
    logic                   hit;
    logic                   renew;
    logic                   altered;
    logic [NAME_W-1:0]      out_name_hi;
    logic [NAME_W-1:0]      out_name_lo;
    logic [OUT_COUNT_W-1:0] entry_count;

    session_key_rotation_table_unit #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .now        (now),
        .name_hi    (name_hi),
        .name_lo    (name_lo),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .hit        (hit),
        .renew      (renew),
        .altered    (altered),
        .out_name_hi(out_name_hi),
        .out_name_lo(out_name_lo),
        .entry_count(entry_count)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Table model state: newest entry in slot 0
    // ------------------------------------------------------------------
    logic [NAME_W-1:0] slot_hi    [TABLE_DEPTH];
    logic [NAME_W-1:0] slot_lo    [TABLE_DEPTH];
    logic [TIME_W-1:0] slot_start [TABLE_DEPTH];
    logic [TIME_W-1:0] slot_stop  [TABLE_DEPTH];
    int                slot_count   = 0;
    logic [LIFE_W-1:0] lifetime_now = LIFETIME_RESET;

    key_reply_t   awaited_replies[$];   // one per accepted request, oldest first
    key_reply_t   oldest;
    stim_row_t    directed_rows[$];
    logic [127:0] name_log[$];          // recently inserted names, for decrypt hits
    bit           gaps_on     = 1'b1;
    int           fail_count  = 0;
    int           cycle_count = 0;

    // Time sum clamped at the all-ones time.
    function automatic logic [TIME_W-1:0] clamp_add(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_TOP : s[TIME_W-1:0];
    endfunction

    // First entry (newest first) that has started decides; -1 if it has
    // already expired or nothing has started yet.
    function automatic int usable_slot(input logic [TIME_W-1:0] t);
        for (int i = 0; i < slot_count; i++) begin
            if (slot_start[i] <= t)
                return (t <= slot_stop[i]) ? i : -1;
        end
        return -1;
    endfunction

    // Applies one request to the model and returns the reply it must give.
    function automatic key_reply_t key_table_step(input logic [CMD_W-1:0]  c,
                                                  input logic [TIME_W-1:0] t,
                                                  input logic [NAME_W-1:0] nhi,
                                                  input logic [NAME_W-1:0] nlo);
        key_reply_t        r;
        int                pick;
        logic [TIME_W-1:0] life;
        logic [TIME_W-1:0] first;
        logic [TIME_W-1:0] last;
        r = '0;
        // zero lifetime behaves as one second
        life = (lifetime_now == '0) ? TIME_W'(1) : TIME_W'(lifetime_now);
        if (c == CMD_ROTATE) begin
            // expired entries leave from the old end
            while (slot_count != 0 && t > slot_stop[slot_count-1]) begin
                slot_count--;
                r.altered = 1'b1;
            end
            pick = usable_slot(t);
            if (pick < 0 || clamp_add(slot_start[0], life >> 2) < t) begin
                // start a minute ahead only while a usable key still exists
                first = (pick >= 0) ? clamp_add(t, AHEAD_SECONDS) : t;
                last  = clamp_add(first, life - 1);
                if (slot_count >= TABLE_DEPTH)
                    slot_count = TABLE_DEPTH - 1;
                for (int i = slot_count; i > 0; i--) begin
                    slot_hi[i]    = slot_hi[i-1];
                    slot_lo[i]    = slot_lo[i-1];
                    slot_start[i] = slot_start[i-1];
                    slot_stop[i]  = slot_stop[i-1];
                end
                slot_hi[0]    = nhi;
                slot_lo[0]    = nlo;
                slot_start[0] = first;
                slot_stop[0]  = last;
                slot_count++;
                r.altered = 1'b1;
            end
        end else if (c == CMD_ENCRYPT) begin
            pick = usable_slot(t);
            if (pick >= 0) begin
                r.hit     = 1'b1;
                r.name_hi = slot_hi[pick];
                r.name_lo = slot_lo[pick];
            end
        end else if (c == CMD_DECRYPT) begin
            for (int i = 0; i < slot_count; i++) begin
                if (slot_hi[i] == nhi && slot_lo[i] == nlo) begin
                    r.hit     = 1'b1;
                    r.renew   = (i != 0);
                    r.name_hi = slot_hi[i];
                    r.name_lo = slot_lo[i];
                    break;
                end
            end
        end
        r.count = OUT_COUNT_W'(slot_count);
        return r;
    endfunction

    function automatic logic [NAME_W-1:0] rand_name();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [7:0] top;
        top = 8'($urandom);
        return {top, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic key_reply_t outcome(input logic h, input logic rn, input logic a,
                                           input logic [NAME_W-1:0] ohi,
                                           input logic [NAME_W-1:0] olo,
                                           input logic [OUT_COUNT_W-1:0] cnt);
        key_reply_t r;
        r = '{h, rn, a, ohi, olo, cnt};
        return r;
    endfunction

    function automatic stim_row_t req(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                                      input logic [NAME_W-1:0] nhi,
                                      input logic [NAME_W-1:0] nlo);
        stim_row_t row;
        row = '{ROW_REQUEST, c, t, nhi, nlo, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t req_chk(input logic [CMD_W-1:0] c,
                                          input logic [TIME_W-1:0] t,
                                          input logic [NAME_W-1:0] nhi,
                                          input logic [NAME_W-1:0] nlo,
                                          input key_reply_t want);
        stim_row_t row;
        row = '{ROW_REQUEST, c, t, nhi, nlo, '0, 1'b1, want};
        return row;
    endfunction

    function automatic stim_row_t life_row(input logic [LIFE_W-1:0] v);
        stim_row_t row;
        row = '{ROW_LIFETIME, CMD_ROTATE, '0, '0, '0, v, 1'b0, '0};
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Called just after a rising edge; leaves start high
    // so a following request can go out back to back. The request is
    // taken at the first edge with start high and busy low.
    // ------------------------------------------------------------------
    task automatic issue_request(input logic [CMD_W-1:0]  c,
                                 input logic [TIME_W-1:0] t,
                                 input logic [NAME_W-1:0] nhi,
                                 input logic [NAME_W-1:0] nlo,
                                 input bit                typed,
                                 input key_reply_t        want);
        key_reply_t forecast;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start   <= 1'b1;
        cmd     <= c;
        now     <= t;
        name_hi <= nhi;
        name_lo <= nlo;
        do @(posedge clk); while (busy);
        // model always advances so typed rows keep its state in step
        forecast = key_table_step(c, t, nhi, nlo);
        awaited_replies.push_back(typed ? want : forecast);
    endtask

    // Lifetime write, only with nothing in flight. Always waits for a clock
    // edge first so cfg_valid is never dropped and raised in the same step.
    task automatic program_lifetime(input logic [LIFE_W-1:0] v);
        start <= 1'b0;
        do @(posedge clk); while (awaited_replies.size() != 0 || busy);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lifetime_now = v;
    endtask

    task automatic log_name(input logic [127:0] pair);
        name_log.push_back(pair);
        if (name_log.size() > 24)
            name_log.delete(0);
    endtask

    // ------------------------------------------------------------------
    // Random phase: a running clock tcur that rotates move forward, with
    // lookups near it, decrypts of recent names (some with a bit flipped),
    // bursts of rotates going back in time to fill and overflow the table,
    // and some fully random noise.
    // ------------------------------------------------------------------
    task automatic run_phase(input logic [LIFE_W-1:0] life, input logic [TIME_W-1:0] t0,
                             input int quota);
        int                issued;
        int                pick;
        logic [TIME_W-1:0] tcur;
        logic [TIME_W-1:0] t;
        logic [NAME_W-1:0] hi;
        logic [NAME_W-1:0] lo;
        logic [127:0]      pair;
        logic [31:0]       stride;
        program_lifetime(life);
        tcur   = t0;
        stride = (life < 4) ? 32'd2 : (life >> 1);
        issued = 0;
        while (issued < quota) begin
            pick = $urandom_range(0, 99);
            hi   = rand_name();
            lo   = rand_name();
            if (pick < 4) begin
                // rotates stepping back in time from tcur
                t = tcur;
                repeat ($urandom_range(3, 10)) begin
                    t  = (t > 40'd100) ? t - TIME_W'($urandom_range(1, 100)) : t;
                    hi = rand_name();
                    lo = rand_name();
                    issue_request(CMD_ROTATE, t, hi, lo, 1'b0, '0);
                    log_name({hi, lo});
                    issued++;
                end
            end else begin
                if (pick < 40) begin
                    issue_request(CMD_ROTATE, tcur, hi, lo, 1'b0, '0);
                    log_name({hi, lo});
                    tcur = clamp_add(tcur, TIME_W'($urandom_range(0, stride)));
                end else if (pick < 62) begin
                    t = TIME_W'($urandom_range(0, 120));
                    t = $urandom_range(0, 1) ? clamp_add(tcur, t)
                                             : ((tcur > t) ? tcur - t : '0);
                    issue_request(CMD_ENCRYPT, t, hi, lo, 1'b0, '0);
                end else if (pick < 88) begin
                    pair = (name_log.size() == 0) ? {hi, lo}
                         : name_log[$urandom_range(0, name_log.size() - 1)];
                    if (pick >= 80)
                        pair = pair ^ (128'd1 << $urandom_range(0, 127));
                    issue_request(CMD_DECRYPT, rand_time(), pair[127:64], pair[63:0],
                                  1'b0, '0);
                end else if (pick < 97) begin
                    issue_request(CMD_W'($urandom_range(0, 3)), rand_time(), hi, lo,
                                  1'b0, '0);
                end else begin
                    issue_request(CMD_UNUSED, rand_time(), hi, lo, 1'b0, '0);
                end
                issued++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled at the edge that
    // ends its cycle; each result pairs with the oldest request.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (awaited_replies.size() == 0) begin
                $error("result strobe with no request outstanding");
                fail_count++;
            end else begin
                oldest = awaited_replies.pop_front();
                if (hit !== oldest.hit) begin
                    $error("hit: expected %0d, actual %0d", oldest.hit, hit);
                    fail_count++;
                end
                if (renew !== oldest.renew) begin
                    $error("renew: expected %0d, actual %0d", oldest.renew, renew);
                    fail_count++;
                end
                if (altered !== oldest.altered) begin
                    $error("altered: expected %0d, actual %0d", oldest.altered, altered);
                    fail_count++;
                end
                if (out_name_hi !== oldest.name_hi) begin
                    $error("out_name_hi: expected %h, actual %h", oldest.name_hi,
                           out_name_hi);
                    fail_count++;
                end
                if (out_name_lo !== oldest.name_lo) begin
                    $error("out_name_lo: expected %h, actual %h", oldest.name_lo,
                           out_name_lo);
                    fail_count++;
                end
                if (entry_count !== oldest.count) begin
                    $error("entry_count: expected %0d, actual %0d", oldest.count,
                           entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        // Directed table. Starts at lifetime 3600 from reset.
        // Empty table: lookups miss, unused code is a no-op.
        directed_rows.push_back(req_chk(CMD_ENCRYPT, '0, '0, '0,
                                        outcome(0, 0, 0, '0, '0, 4'd0)));
        directed_rows.push_back(req_chk(CMD_DECRYPT, '0, '1, '1,
                                        outcome(0, 0, 0, '0, '0, 4'd0)));
        directed_rows.push_back(req_chk(CMD_UNUSED, TIME_TOP, '1, '1,
                                        outcome(0, 0, 0, '0, '0, 4'd0)));
        // First rotate on an empty table inserts at now.
        directed_rows.push_back(req_chk(CMD_ROTATE, 40'd1000, '0, '0,
                                        outcome(0, 0, 1, '0, '0, 4'd1)));
        // Exactly lifetime/4 old: no insert; one second later: insert 60 s ahead.
        directed_rows.push_back(req(CMD_ROTATE, 40'd1900, '1, '1));
        directed_rows.push_back(req(CMD_ROTATE, 40'd1901, '1, '1));
        // Newest not started yet, so the older key serves.
        directed_rows.push_back(req(CMD_ENCRYPT, 40'd1901, '0, '0));
        // Decrypt of the older key asks for renewal; of the newest does not.
        directed_rows.push_back(req(CMD_DECRYPT, '0, '0, '0));
        directed_rows.push_back(req(CMD_DECRYPT, '0, '1, '1));
        // Oldest expires while a usable key is left: drop and insert together.
        directed_rows.push_back(req(CMD_ROTATE, 40'd4600, 64'h0123_4567_89AB_CDEF,
                                    64'hFEDC_BA98_7654_3210));
        // Zero lifetime acts as one second.
        directed_rows.push_back(life_row('0));
        directed_rows.push_back(req(CMD_ROTATE, 40'd10000, 64'h5555_5555_5555_5555,
                                    64'hAAAA_AAAA_AAAA_AAAA));
        directed_rows.push_back(req(CMD_ENCRYPT, 40'd10001, '0, '0));
        // Largest lifetime, times near the top: window end saturates.
        directed_rows.push_back(life_row('1));
        directed_rows.push_back(req(CMD_ROTATE, TIME_TOP - 40'd10,
                                    64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE));
        directed_rows.push_back(req(CMD_ROTATE, TIME_TOP, 64'd1, 64'd2));
        // Rotates going back in time each insert: fill, then overflow.
        for (int j = 1; j <= TABLE_DEPTH; j++)
            directed_rows.push_back(req_chk(CMD_ROTATE, TIME_W'(900 - 100 * j),
                                            NAME_W'(j), ~NAME_W'(j),
                                            outcome(0, 0, 1, '0, '0,
                                                    (j + 1 > TABLE_DEPTH) ?
                                                    OUT_COUNT_W'(TABLE_DEPTH) :
                                                    OUT_COUNT_W'(j + 1))));
        // The entry pushed off the old end no longer matches.
        directed_rows.push_back(req_chk(CMD_DECRYPT, '0, 64'h8000_0000_0000_0001,
                                        64'h7FFF_FFFF_FFFF_FFFE,
                                        outcome(0, 0, 0, '0, '0, 4'd8)));
        // Short lifetime near the top: now+60 saturates.
        directed_rows.push_back(life_row(32'd4));
        directed_rows.push_back(req(CMD_ROTATE, TIME_TOP - 40'd28, 64'd3, 64'd4));
        directed_rows.push_back(req(CMD_ROTATE, TIME_TOP - 40'd26, 64'd5, 64'd6));
        directed_rows.push_back(req(CMD_ENCRYPT, TIME_TOP - 40'd26, '0, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_LIFETIME)
                program_lifetime(directed_rows[i].life);
            else
                issue_request(directed_rows[i].cmd, directed_rows[i].t,
                              directed_rows[i].nhi, directed_rows[i].nlo,
                              directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases across lifetimes, extremes included.
        run_phase(32'd3600, TIME_W'($urandom_range(0, 1000000)), 90);
        run_phase(32'd1, rand_time() >> 1, 70);
        run_phase(32'd4, TIME_TOP - 40'd300, 60);
        run_phase(32'hFFFF_FFFF, rand_time() >> 1, 80);
        run_phase(LIFE_W'($urandom_range(2, 100000)), rand_time() >> 2, 80);
        run_phase(32'hFFFF_FFFF, TIME_TOP - 40'h4_0000_0000, 60);
        // closing stretch runs back to back
        gaps_on = 1'b0;
        run_phase(LIFETIME_RESET, rand_time() >> 1, 60);

        // Drain, then wait on to catch any stray strobe.
        start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
